// File: rtl/bavg_pkg.sv
// Shared types, constants and register indexes for the block average downsampler.
package bavg_pkg;

    // Default sizing, handed to the top level parameters
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_FACTOR = 16;

    // Frame height limit and the fixed field widths
    localparam int MAX_HEIGHT = 1024;
    localparam int HGT_W      = 11;
    localparam int PIX_W      = 8;
    localparam int COL_OUT_W  = 10;
    localparam int ROW_OUT_W  = 10;
    localparam int M_FIELD_W  = PIX_W + COL_OUT_W + ROW_OUT_W;
    localparam int M_TDATA_W  = ((M_FIELD_W + 7) / 8) * 8;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int FACTOR_W   = 5;
    localparam int IMG_DIM_W  = 11;

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_FACTOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

    localparam logic [FACTOR_W-1:0]  RST_BLOCK_FACTOR = 5'd2;
    localparam logic [IMG_DIM_W-1:0] RST_IMAGE_WIDTH  = 11'd640;
    localparam logic [IMG_DIM_W-1:0] RST_IMAGE_HEIGHT = 11'd480;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACC,
        ST_DIV
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic acc_en;
        logic div_start;
        logic out_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic block_done;
        logic div_done;
        logic out_busy;
    } sts_t;

endpackage

// File: rtl/bavg_div.sv
// Restoring divider, one quotient bit per cycle.
module bavg_div #(
    parameter int DIVIDEND_W = 16,
    parameter int DIVISOR_W  = 10
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic [DIVIDEND_W-1:0] quotient,
    output logic                  busy,
    output logic                  done
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  dsr_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [DIVISOR_W:0]    rem_shift;
    logic [DIVISOR_W:0]    rem_diff;
    logic                  ge;

    always_comb begin
        rem_shift = {rem_reg, quo_reg[DIVIDEND_W-1]};
        rem_diff  = rem_shift - {1'b0, dsr_reg};
        ge        = (rem_shift >= {1'b0, dsr_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DIVIDEND_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], ge};
            rem_reg <= ge ? rem_diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
        end
    end

    assign quotient = quo_reg;
    assign busy     = busy_reg;
    assign done     = done_reg;

endmodule

// File: rtl/bavg_datapath.sv
// Datapath: config registers, raster counters, column sum memory, divider, output register.
module bavg_datapath #(
    parameter int MAX_WIDTH  = bavg_pkg::DEF_MAX_WIDTH,
    parameter int MAX_FACTOR = bavg_pkg::DEF_MAX_FACTOR
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [bavg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bavg_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic [bavg_pkg::PIX_W-1:0]          s_tdata,
    input  bavg_pkg::cmd_t                      cmd,
    output bavg_pkg::sts_t                      sts,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic [bavg_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tlast
);

    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int FW    = $clog2(MAX_FACTOR + 1);
    localparam int SW    = bavg_pkg::PIX_W + 2 * $clog2(MAX_FACTOR);
    localparam int DW    = 2 * FW;
    localparam int HW    = bavg_pkg::HGT_W;
    localparam int RW    = bavg_pkg::ROW_OUT_W;
    localparam int PAD_W = bavg_pkg::M_TDATA_W - bavg_pkg::M_FIELD_W;

    // Configuration
    logic [bavg_pkg::FACTOR_W-1:0]  factor_reg;
    logic [bavg_pkg::IMG_DIM_W-1:0] width_reg;
    logic [bavg_pkg::IMG_DIM_W-1:0] height_reg;
    logic                           restart;

    logic [FW-1:0] f_eff;
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic [DW-1:0] divisor;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            factor_reg <= bavg_pkg::RST_BLOCK_FACTOR;
            width_reg  <= bavg_pkg::RST_IMAGE_WIDTH;
            height_reg <= bavg_pkg::RST_IMAGE_HEIGHT;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                bavg_pkg::REG_BLOCK_FACTOR: factor_reg <= cfg_wdata[bavg_pkg::FACTOR_W-1:0];
                bavg_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_wdata[bavg_pkg::IMG_DIM_W-1:0];
                bavg_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_wdata[bavg_pkg::IMG_DIM_W-1:0];
                default: ;
            endcase
        end
    end

    assign restart = cfg_wr_en && (cfg_index == bavg_pkg::REG_BLOCK_FACTOR ||
                                   cfg_index == bavg_pkg::REG_IMAGE_WIDTH ||
                                   cfg_index == bavg_pkg::REG_IMAGE_HEIGHT);

    // Clamp the registers into their working ranges
    always_comb begin
        if (factor_reg == '0)
            f_eff = FW'(1);
        else if (32'(factor_reg) > MAX_FACTOR)
            f_eff = FW'(MAX_FACTOR);
        else
            f_eff = FW'(factor_reg);

        if (width_reg == '0)
            w_eff = WW'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(width_reg);

        if (height_reg == '0)
            h_eff = HW'(1);
        else if (32'(height_reg) > bavg_pkg::MAX_HEIGHT)
            h_eff = HW'(bavg_pkg::MAX_HEIGHT);
        else
            h_eff = HW'(height_reg);

        divisor = DW'(f_eff) * DW'(f_eff);
    end

    // Raster position counters
    logic [WW-1:0] pcol_reg, pcol_next;
    logic [HW-1:0] prow_reg, prow_next;
    logic [FW-1:0] ibc_reg,  ibc_next;
    logic [FW-1:0] ibr_reg,  ibr_next;
    logic [AW-1:0] bcol_reg, bcol_next;
    logic [RW-1:0] brow_reg, brow_next;
    logic [WW-1:0] scol_reg, scol_next;   // first pixel column of current block
    logic [HW-1:0] srow_reg, srow_next;   // first pixel row of current block

    logic [WW:0]   pcol_inc;
    logic [HW:0]   prow_inc;
    logic [FW-1:0] ibc_inc;
    logic [FW-1:0] ibr_inc;

    logic col_fit, row_fit, col_last, row_last;
    logic in_region, blk_first, blk_last;

    always_comb begin
        col_fit   = ({1'b0, scol_reg} + (WW+1)'(f_eff)) <= {1'b0, w_eff};
        row_fit   = ({1'b0, srow_reg} + (HW+1)'(f_eff)) <= {1'b0, h_eff};
        col_last  = ({2'b00, scol_reg} + (WW+2)'({f_eff, 1'b0})) > (WW+2)'(w_eff);
        row_last  = ({2'b00, srow_reg} + (HW+2)'({f_eff, 1'b0})) > (HW+2)'(h_eff);
        in_region = col_fit && row_fit;
        blk_first = (ibc_reg == '0) && (ibr_reg == '0);
        blk_last  = (ibc_reg == f_eff - FW'(1)) && (ibr_reg == f_eff - FW'(1));
    end

    always_comb begin
        pcol_inc  = {1'b0, pcol_reg} + (WW+1)'(1);
        prow_inc  = {1'b0, prow_reg} + (HW+1)'(1);
        ibc_inc   = ibc_reg + FW'(1);
        ibr_inc   = ibr_reg + FW'(1);
        pcol_next = pcol_reg;
        prow_next = prow_reg;
        ibc_next  = ibc_reg;
        ibr_next  = ibr_reg;
        bcol_next = bcol_reg;
        brow_next = brow_reg;
        scol_next = scol_reg;
        srow_next = srow_reg;
        if (restart) begin
            pcol_next = '0;
            prow_next = '0;
            ibc_next  = '0;
            ibr_next  = '0;
            bcol_next = '0;
            brow_next = '0;
            scol_next = '0;
            srow_next = '0;
        end else if (cmd.accept) begin
            pcol_next = pcol_inc[WW-1:0];
            if (ibc_inc >= f_eff) begin
                ibc_next  = '0;
                bcol_next = bcol_reg + AW'(1);
                scol_next = scol_reg + WW'(f_eff);
            end else begin
                ibc_next = ibc_inc;
            end
            // End of an input row
            if (pcol_inc >= (WW+1)'(w_eff)) begin
                pcol_next = '0;
                ibc_next  = '0;
                bcol_next = '0;
                scol_next = '0;
                prow_next = prow_inc[HW-1:0];
                if (ibr_inc >= f_eff) begin
                    ibr_next  = '0;
                    brow_next = brow_reg + RW'(1);
                    srow_next = srow_reg + HW'(f_eff);
                end else begin
                    ibr_next = ibr_inc;
                end
                // End of frame
                if (prow_inc >= (HW+1)'(h_eff)) begin
                    prow_next = '0;
                    ibr_next  = '0;
                    brow_next = '0;
                    srow_next = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pcol_reg <= '0;
            prow_reg <= '0;
            ibc_reg  <= '0;
            ibr_reg  <= '0;
            bcol_reg <= '0;
            brow_reg <= '0;
            scol_reg <= '0;
            srow_reg <= '0;
        end else begin
            pcol_reg <= pcol_next;
            prow_reg <= prow_next;
            ibc_reg  <= ibc_next;
            ibr_reg  <= ibr_next;
            bcol_reg <= bcol_next;
            brow_reg <= brow_next;
            scol_reg <= scol_next;
            srow_reg <= srow_next;
        end
    end

    // Item captured at accept
    logic [bavg_pkg::PIX_W-1:0] pix_reg;
    logic                       use_reg;
    logic                       first_reg;
    logic                       last_reg;
    logic                       fend_reg;
    logic [AW-1:0]              addr_reg;
    logic [RW-1:0]              row_reg;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            pix_reg   <= s_tdata;
            use_reg   <= in_region;
            first_reg <= blk_first;
            last_reg  <= blk_last;
            fend_reg  <= col_last && row_last;
            addr_reg  <= bcol_reg;
            row_reg   <= brow_reg;
        end
    end

    // Column sum memory: read at accept, written back in the following cycle.
    // The first pixel of a block reloads the entry, so no clearing is needed.
    logic [SW-1:0] sum_mem [MAX_WIDTH];
    logic [SW-1:0] rd_data_reg;
    logic [SW-1:0] sum;
    logic          mem_we;

    assign sum    = first_reg ? SW'(pix_reg) : rd_data_reg + SW'(pix_reg);
    assign mem_we = cmd.acc_en && use_reg;

    always_ff @(posedge aclk) begin
        if (cmd.accept)
            rd_data_reg <= sum_mem[bcol_reg];
        if (mem_we)
            sum_mem[addr_reg] <= sum;
    end

    // Block mean
    logic [SW-1:0] quotient;
    logic          div_busy;
    logic          div_done;

    bavg_div #(
        .DIVIDEND_W (SW),
        .DIVISOR_W  (DW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (sum),
        .divisor  (divisor),
        .quotient (quotient),
        .busy     (div_busy),
        .done     (div_done)
    );

    // Output register
    logic                              out_valid_reg;
    logic [bavg_pkg::PIX_W-1:0]        mean_reg;
    logic [bavg_pkg::COL_OUT_W-1:0]    ocol_reg;
    logic [RW-1:0]                     orow_reg;
    logic                              olast_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            mean_reg  <= quotient[bavg_pkg::PIX_W-1:0];
            ocol_reg  <= bavg_pkg::COL_OUT_W'(addr_reg);
            orow_reg  <= row_reg;
            olast_reg <= fend_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, orow_reg, ocol_reg, mean_reg};
    assign m_tlast  = olast_reg;

    assign sts.block_done = use_reg && last_reg;
    assign sts.div_done   = div_done;
    assign sts.out_busy   = out_valid_reg && !m_tready;

    // Checks
    a_acc_follows_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |=> cmd.acc_en)
        else $error("accumulate step did not follow an accepted pixel");

    a_no_accept_in_divide: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |-> !div_busy)
        else $error("pixel accepted while divider busy");

    a_mean_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (quotient[SW-1:bavg_pkg::PIX_W] == '0))
        else $error("block mean overflows pixel width");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !(out_valid_reg && !m_tready))
        else $error("output register overwritten while held");

endmodule

// File: rtl/bavg_ctrl.sv
// Controller state machine: accept, accumulate, divide, hand off to the output register.
module bavg_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  bavg_pkg::sts_t sts,
    output bavg_pkg::cmd_t cmd
);

    bavg_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn)
            state_reg <= bavg_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bavg_pkg::ST_IDLE: begin
                if (s_tvalid)
                    state_next = bavg_pkg::ST_ACC;
            end
            bavg_pkg::ST_ACC: begin
                if (sts.block_done)
                    state_next = bavg_pkg::ST_DIV;
                else
                    state_next = bavg_pkg::ST_IDLE;
            end
            bavg_pkg::ST_DIV: begin
                if (sts.div_done && !sts.out_busy)
                    state_next = bavg_pkg::ST_IDLE;
            end
            default: state_next = bavg_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready      = 1'b0;
        cmd.accept    = 1'b0;
        cmd.acc_en    = 1'b0;
        cmd.div_start = 1'b0;
        cmd.out_load  = 1'b0;
        unique case (state_reg)
            bavg_pkg::ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            bavg_pkg::ST_ACC: begin
                cmd.acc_en    = 1'b1;
                cmd.div_start = sts.block_done;
            end
            bavg_pkg::ST_DIV: begin
                cmd.out_load = sts.div_done && !sts.out_busy;
            end
            default: ;
        endcase
    end

endmodule

// File: rtl/block_average_downsampler.sv
// Top level of the block average downsampler (box filter, block mean).
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------------
//  s_      | in        | s_tvalid/s_tready  | s_tdata[7:0] pixel
//  m_      | out       | m_tvalid/m_tready  | m_tdata mean/col/row, m_tlast frame_end
//  cfg_    | in        | cfg_wr_en          | cfg_index, cfg_wdata (no read-back)
//
//  Steps: a pixel that does not close a block is accepted with a column-sum
//  read, then added and written back. A pixel that closes a block adds the
//  serial divider, one quotient bit per cycle (8 + 2*clog2(MAX_FACTOR) bits,
//  16 at the defaults), then loads the output register once it is free.
//  Reset: aresetn low at a clock edge clears counters, control and the output
//  valid; config registers return to factor 2, 640 x 480.
//  Stalls: the output register holds one result while m_tready is low; the next
//  pixel is still accepted and only a second finished block waits for it.
//  A config write to any of the three registers restarts the frame at row 0, column 0.
module block_average_downsampler #(
    parameter int MAX_WIDTH  = bavg_pkg::DEF_MAX_WIDTH,
    parameter int MAX_FACTOR = bavg_pkg::DEF_MAX_FACTOR
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration writes
    input  logic                              cfg_wr_en,
    input  logic [bavg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bavg_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // pixel input
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bavg_pkg::PIX_W-1:0]        s_tdata,   // [7:0] pixel
    // block mean output
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bavg_pkg::M_TDATA_W-1:0]    m_tdata,   // [7:0] mean_value, [17:8] out_col,
                                                         // [27:18] out_row, [31:28] zero
    output logic                              m_tlast    // frame_end
);

    bavg_pkg::cmd_t cmd;
    bavg_pkg::sts_t sts;

    bavg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bavg_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_FACTOR (MAX_FACTOR)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// File: dv/tb.sv
// Self-checking testbench for block_average_downsampler: block means over raster pixel streams.
`timescale 1ns / 1ps

module tb;

    localparam int CFG_IDX_W  = bavg_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = bavg_pkg::CFG_DATA_W;
    localparam int PIX_W      = bavg_pkg::PIX_W;
    localparam int ROW_OUT_W  = bavg_pkg::ROW_OUT_W;
    localparam int COL_OUT_W  = bavg_pkg::COL_OUT_W;
    localparam int M_TDATA_W  = bavg_pkg::M_TDATA_W;
    localparam int FACTOR_W   = bavg_pkg::FACTOR_W;
    localparam int IMG_DIM_W  = bavg_pkg::IMG_DIM_W;
    localparam int MAX_WIDTH  = bavg_pkg::DEF_MAX_WIDTH;
    localparam int MAX_FACTOR = bavg_pkg::DEF_MAX_FACTOR;
    localparam int MAX_HEIGHT = bavg_pkg::MAX_HEIGHT;
    localparam int BLK_W      = $clog2(MAX_WIDTH);
    localparam int SUM_W      = 16;

    // Unused slot of the 2-bit register index; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned RANDOM_PIXELS = 150;

    // One block mean as it appears on m_tdata / m_tlast
    typedef struct packed {
        logic [3:0]           pad;
        logic [ROW_OUT_W-1:0] row;
        logic [COL_OUT_W-1:0] col;
        logic [PIX_W-1:0]     mean;
        logic                 frame_end;
    } block_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [PIX_W-1:0]      s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;

    block_average_downsampler u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor: mirror of the block's registers and counters
    // ------------------------------------------------------------------
    logic [FACTOR_W-1:0]  cfg_factor = bavg_pkg::RST_BLOCK_FACTOR;
    logic [IMG_DIM_W-1:0] cfg_width  = bavg_pkg::RST_IMAGE_WIDTH;
    logic [IMG_DIM_W-1:0] cfg_height = bavg_pkg::RST_IMAGE_HEIGHT;

    logic [SUM_W-1:0] col_sums [MAX_WIDTH];
    logic [10:0] pix_col, pix_row;
    logic [4:0]  sub_col, sub_row;      // position inside the current block
    logic [BLK_W-1:0] blk_col, blk_row;

    block_result_t block_means_q [$];   // expected block means, oldest first

    int unsigned mismatches  = 0;
    int unsigned pixels_sent = 0;
    int unsigned src_idle_pct = 13;
    int unsigned snk_idle_pct = 50;

    function automatic void restart_frame();
        pix_col = '0;
        pix_row = '0;
        sub_col = '0;
        sub_row = '0;
        blk_col = '0;
        blk_row = '0;
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel();
        return PIX_W'($urandom_range(255));
    endfunction

    // Advance the model by one pixel; returns 1 if the pixel falls in a whole block.
    function automatic bit predict_block_mean(input logic [PIX_W-1:0] pix);
        int unsigned   f, w, h, bw, bh;
        bit            used;
        block_result_t r;
        f = (cfg_factor == 0) ? 1 : (cfg_factor > MAX_FACTOR ? MAX_FACTOR : cfg_factor);
        w = (cfg_width == 0) ? 1 : (cfg_width > MAX_WIDTH ? MAX_WIDTH : cfg_width);
        h = (cfg_height == 0) ? 1 : (cfg_height > MAX_HEIGHT ? MAX_HEIGHT : cfg_height);
        bw = w / f;
        bh = h / f;
        used = (pix_col < bw * f) && (pix_row < bh * f);
        if (used) begin
            // first pixel of a block reloads its column sum
            if (sub_col == 0 && sub_row == 0)
                col_sums[blk_col] = SUM_W'(pix);
            else
                col_sums[blk_col] = col_sums[blk_col] + SUM_W'(pix);
            if (sub_col == f - 1 && sub_row == f - 1) begin
                r.pad       = '0;
                r.mean      = PIX_W'(col_sums[blk_col] / (f * f));
                r.col       = COL_OUT_W'(blk_col);
                r.row       = ROW_OUT_W'(blk_row);
                r.frame_end = (blk_col + 1 == bw) && (blk_row + 1 == bh);
                block_means_q.push_back(r);
            end
        end
        pix_col++;
        sub_col++;
        if (sub_col >= f) begin
            sub_col = '0;
            blk_col++;
        end
        if (pix_col >= w) begin
            pix_col = '0;
            sub_col = '0;
            blk_col = '0;
            pix_row++;
            sub_row++;
            if (sub_row >= f) begin
                sub_row = '0;
                blk_row++;
            end
            if (pix_row >= h)
                restart_frame();   // frame wrap
        end
        return used;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random back-pressure and the checker
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge aclk) begin : check_block_means
        block_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[31:28], m_tdata[27:18], m_tdata[17:8], m_tdata[7:0], m_tlast};
            if (block_means_q.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected item, expected none, actual mean %0d col %0d row %0d last %0b pad %h",
                         $time, got.mean, got.col, got.row, got.frame_end, got.pad);
            end else begin
                want = block_means_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    $display("%0t: mismatch expected mean %0d col %0d row %0d last %0b pad %h",
                             $time, want.mean, want.col, want.row, want.frame_end, want.pad);
                    $display("%0t:          actual   mean %0d col %0d row %0d last %0b pad %h",
                             $time, got.mean, got.col, got.row, got.frame_end, got.pad);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared driver tasks (all called right after a rising edge)
    // ------------------------------------------------------------------

    // Valid is left high after an accept; only an idle gap or a drain lowers it.
    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        do @(posedge aclk); while (!s_tready);
        void'(predict_block_mean(pix));
        pixels_sent++;
    endtask

    // Stop sending and wait for every expected item, then let the pipe settle.
    task automatic drain(input int unsigned settle);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (block_means_q.size() != 0);
        repeat (settle) @(posedge aclk);
    endtask

    // Back-to-back writes of all three registers; any write restarts the frame.
    task automatic configure(input logic [CFG_DATA_W-1:0] factor_word,
                             input logic [CFG_DATA_W-1:0] width_word,
                             input logic [CFG_DATA_W-1:0] height_word);
        cfg_wr_en <= 1'b1;
        cfg_index <= bavg_pkg::REG_BLOCK_FACTOR;
        cfg_wdata <= factor_word;
        @(posedge aclk);
        cfg_index <= bavg_pkg::REG_IMAGE_WIDTH;
        cfg_wdata <= width_word;
        @(posedge aclk);
        cfg_index <= bavg_pkg::REG_IMAGE_HEIGHT;
        cfg_wdata <= height_word;
        @(posedge aclk);
        cfg_wr_en  <= 1'b0;
        cfg_factor = factor_word[FACTOR_W-1:0];
        cfg_width  = width_word;
        cfg_height = height_word;
        restart_frame();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Factor 0 acts as 1: every pixel is its own block. Pixel extremes,
    // frame_end on the last one, then wrap into a new frame. Then factor 2
    // at full scale and a truncating mean.
    task automatic test_directed_extremes();
        logic [PIX_W-1:0] unit_pix [10];
        logic [PIX_W-1:0] pair_pix [8];
        unit_pix = '{8'h00, 8'hFF, 8'hAA, 8'h55, 8'h01, 8'h80, 8'hFE, 8'h7F, 8'hC3, 8'h3C};
        pair_pix = '{8'hFF, 8'hFF, 8'hFF, 8'hFE, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        configure(11'd0, 11'd4, 11'd2);
        foreach (unit_pix[i]) send_pixel(unit_pix[i]);
        drain(SETTLE_CYCLES);
        configure(11'd2, 11'd4, 11'd2);
        foreach (pair_pix[i]) send_pixel(pair_pix[i]);
        drain(SETTLE_CYCLES);
    endtask

    // Right column and bottom row of partial blocks are dropped; one frame
    // and the start of the next.
    task automatic test_ragged_edges();
        configure(11'd3, 11'd8, 11'd7);
        repeat (8 * 7 + 5) send_pixel(rand_pixel());
        drain(SETTLE_CYCLES);
    endtask

    // Image smaller than a block gives nothing; upper data bits of the
    // factor write are dropped. Zero width and height act as 1x1.
    task automatic test_tiny_image();
        configure(11'h7E4, 11'd3, 11'd8);
        repeat (30) send_pixel(rand_pixel());
        drain(SETTLE_CYCLES);
        configure(11'd1, 11'd0, 11'd0);
        repeat (3) send_pixel(rand_pixel());
        drain(SETTLE_CYCLES);
    endtask

    // A write to the spare index must neither restart the frame nor change a register.
    task automatic test_spare_register();
        configure(11'd2, 11'd6, 11'd4);
        repeat (7) send_pixel(rand_pixel());
        drain(SETTLE_CYCLES);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_SPARE;
        cfg_wdata <= CFG_DATA_W'($urandom_range(2047));
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        repeat (17 + 24) send_pixel(rand_pixel());
        drain(SETTLE_CYCLES);
    endtask

    // Factor 31 clamps to 16: one 16x16 block.
    task automatic test_factor_clamp();
        configure(11'd31, 11'd16, 11'd16);
        repeat (256) send_pixel(rand_pixel());
        drain(SETTLE_CYCLES);
    endtask

    // Width 2047 clamps to 1024: one long row of one-pixel blocks.
    task automatic test_width_clamp();
        configure(11'd1, 11'd2047, 11'd1);
        repeat (24) send_pixel(rand_pixel());
        drain(SETTLE_CYCLES);
    endtask

    // Height 2047 clamps to 1024: one tall column of one-pixel blocks.
    task automatic test_height_clamp();
        configure(11'd1, 11'd1, 11'd2047);
        repeat (24) send_pixel(rand_pixel());
        drain(SETTLE_CYCLES);
    endtask

    // Random geometry per phase, mostly whole small frames with random pixels,
    // some larger factors and a few out-of-range register values.
    task automatic test_random_frames();
        int unsigned f, w, h, n, sel, start_count;
        bit          paused;
        logic [CFG_DATA_W-1:0] factor_word;
        paused = 1'b0;
        start_count = pixels_sent;
        while (pixels_sent - start_count < RANDOM_PIXELS) begin
            if (pixels_sent - start_count >= 2 * RANDOM_PIXELS / 3) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end else if (pixels_sent - start_count >= RANDOM_PIXELS / 3) begin
                src_idle_pct = 50;
                snk_idle_pct = 13;
            end
            sel = $urandom_range(9);
            if (sel < 7) begin
                f = $urandom_range(1, 4);
                w = $urandom_range(f, 24);
                h = $urandom_range(f, 12);
                factor_word = CFG_DATA_W'(f);
                n = (w * h <= 80) ? w * h * $urandom_range(1, 2) : $urandom_range(20, 120);
            end else if (sel < 9) begin
                f = $urandom_range(5, 8);
                w = $urandom_range(f, 16);
                h = $urandom_range(f, 10);
                factor_word = CFG_DATA_W'(f);
                n = w * h;
            end else begin
                // noise: arbitrary register words, clamping applies
                factor_word = CFG_DATA_W'($urandom_range(2047));
                w = $urandom_range(2047);
                h = $urandom_range(2047);
                n = $urandom_range(1, 40);
            end
            drain(SETTLE_CYCLES);
            configure(factor_word, CFG_DATA_W'(w), CFG_DATA_W'(h));
            for (int unsigned i = 0; i < n; i++) begin
                send_pixel(rand_pixel());
                // hold the source until the output side has caught up
                if (i == n / 2 && (!paused || $urandom_range(3) == 0)) begin
                    drain(0);
                    paused = 1'b1;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        foreach (col_sums[i]) col_sums[i] = '0;
        restart_frame();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        src_idle_pct = 13;
        snk_idle_pct = 50;
        test_directed_extremes();
        test_ragged_edges();
        test_tiny_image();
        test_spare_register();
        test_factor_clamp();
        test_width_clamp();
        test_height_clamp();
        test_random_frames();
        drain(SETTLE_CYCLES);

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog, several times the slowest legal run
    initial begin
        #5ms;
        $display("%0t: watchdog expired", $time);
        $display("== FAIL ==");
        $finish;
    end

endmodule
